FILE: rtl/radio_reply_deframer_crc8_unit_defines.svh
// Assertion macros shared by the deframer RTL
`ifndef RADIO_REPLY_DEFRAMER_CRC8_UNIT_DEFINES_SVH
`define RADIO_REPLY_DEFRAMER_CRC8_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RRD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define RRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rrd_pkg.sv
// Types and constants of the radio reply deframer
`default_nettype none

package rrd_pkg;

    localparam logic [7:0] PREAMBLE_BYTE = 8'hA5;
    localparam logic [7:0] CRC_POLY      = 8'h8C;
    localparam logic [7:0] CRC_SEED      = 8'h00;

    localparam int unsigned HEADER_BYTES = 7;
    localparam int unsigned MIN_FRAME    = 8;

    // byte positions of the header fields
    localparam int unsigned POS_PREAMBLE = 0;
    localparam int unsigned POS_DEST     = 2;
    localparam int unsigned POS_ID_HI    = 3;
    localparam int unsigned POS_ID_LO    = 4;
    localparam int unsigned POS_TYPE     = 5;
    localparam int unsigned POS_LEN      = 6;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ID        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ID   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_LIMIT = 2'd2;

    localparam logic [7:0] PAYLOAD_LIMIT_RESET = 8'd32;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_PREAMBLE  = 4'd2,
        ST_CRC       = 4'd3,
        ST_ADDRESS   = 4'd4,
        ST_MSGID     = 4'd5,
        ST_LENGTH    = 4'd6,
        ST_TOO_BIG   = 4'd7,
        ST_TOO_LONG  = 4'd8
    } status_t;

    typedef struct packed {
        logic       is_verdict;
        logic [7:0] payload_byte;
        status_t    status;
        logic [7:0] msg_type;
        logic [7:0] payload_len;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/rrd_crc8.sv
// CRC-8 (reflected 0x8C) update over one byte, bit by bit
`default_nettype none

module rrd_crc8 (
    input  wire logic [7:0] crc_in,
    input  wire logic [7:0] data_in,
    output logic      [7:0] crc_out
);
    import rrd_pkg::*;

    always_comb
    begin
        logic [7:0] crc;
        logic [7:0] d;
        crc = crc_in;
        d   = data_in;
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0] ^ d[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
            d = d >> 1;
        end
        crc_out = crc;
    end

endmodule

`default_nettype wire

FILE: rtl/radio_reply_deframer_crc8_unit.sv
// Top level: radio reply deframer with CRC-8 check
//
// Packet bytes come in on the item channel (item_valid / item_stall), with
// end_of_packet high on the trailing CRC byte. Each payload byte is handed
// out as a tentative transaction on the result channel (is_verdict = 0);
// the CRC byte yields one verdict transaction (is_verdict = 1) carrying
// status, msg_type and payload_len. Header bytes and trailing bytes give
// no transaction.
// Each result is registered in the output buffer before the result channel
// shows it. Throughput: one byte per cycle while item_stall is low; the
// byte update (CRC, header capture, checks) is one combinational pass into the buffer.
// A two-entry output buffer (result register plus skid entry) lets a
// byte be taken while a result waits; item_stall rises only when both
// entries are full, and drops once the receiver takes a result.
// Reset clears the packet state, the output buffer and the registers
// (payload_limit = 32). The user writes the registers through cfg_we /
// cfg_index / cfg_data only while the block is idle; it is not enforced.
`default_nettype none
`include "radio_reply_deframer_crc8_unit_defines.svh"

module radio_reply_deframer_crc8_unit #(
    parameter int MAX_PACKET_BYTES = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_we,
    input  wire logic [rrd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [rrd_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire logic [7:0]                        rx_byte,
    input  wire logic                              end_of_packet,

    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output logic                                   is_verdict,
    output logic [7:0]                             payload_byte,
    output rrd_pkg::status_t                       status,
    output logic [7:0]                             msg_type,
    output logic [7:0]                             payload_len
);
    import rrd_pkg::*;

    // count holds up to MAX_PACKET_BYTES + 1, total up to MAX_PACKET_BYTES + 2
    localparam int CW = $clog2(MAX_PACKET_BYTES + 3);
    localparam int LW = (CW > 8) ? CW : 8;

    // configuration
    logic [7:0]  own_device_id_reg;
    logic [15:0] expected_msg_id_reg;
    logic [7:0]  payload_limit_reg;

    // packet state
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [7:0]    running_crc_reg, running_crc_next;
    logic          preamble_seen_reg, preamble_seen_next;
    logic [7:0]    dest_addr_reg, dest_addr_next;
    logic [15:0]   rx_msg_id_reg, rx_msg_id_next;
    logic [7:0]    rx_type_reg, rx_type_next;
    logic [7:0]    rx_length_reg, rx_length_next;

    // output buffer
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;

    logic       accept;
    logic       take;
    logic       has_result;
    result_t    new_result;
    status_t    verdict;
    logic [7:0] crc_upd;
    logic [CW-1:0] pos;
    logic [LW-1:0] body_bytes;
    logic [LW-1:0] length_ext;

    rrd_crc8 u_crc (
        .crc_in  (running_crc_reg),
        .data_in (rx_byte),
        .crc_out (crc_upd)
    );

    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !skid_valid_reg;
    assign take       = main_valid_reg && !result_stall;
    assign pos        = byte_count_reg;
    assign length_ext = LW'(rx_length_reg);
    // payload bytes taken before the current byte
    assign body_bytes = LW'(pos) - LW'(HEADER_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_device_id_reg   <= '0;
            expected_msg_id_reg <= '0;
            payload_limit_reg   <= PAYLOAD_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_ID:        own_device_id_reg   <= cfg_data[7:0];
                CFG_EXPECTED_ID:   expected_msg_id_reg <= cfg_data[15:0];
                CFG_PAYLOAD_LIMIT: payload_limit_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // verdict, checked in priority order
    always_comb
    begin
        if (pos >= CW'(MAX_PACKET_BYTES))
            verdict = ST_TOO_LONG;
        else if (pos < CW'(MIN_FRAME - 1))
            verdict = ST_SHORT;
        else if (!preamble_seen_reg)
            verdict = ST_PREAMBLE;
        else if (running_crc_reg != rx_byte)
            verdict = ST_CRC;
        else if (dest_addr_reg != own_device_id_reg && dest_addr_reg != 8'd0)
            verdict = ST_ADDRESS;
        else if (rx_msg_id_reg != expected_msg_id_reg)
            verdict = ST_MSGID;
        else if (length_ext > body_bytes)
            verdict = ST_LENGTH;
        else if (rx_length_reg != 8'd0 && rx_length_reg > payload_limit_reg)
            verdict = ST_TOO_BIG;
        else
            verdict = ST_OK;
    end

    always_comb
    begin
        byte_count_next    = byte_count_reg;
        running_crc_next   = running_crc_reg;
        preamble_seen_next = preamble_seen_reg;
        dest_addr_next     = dest_addr_reg;
        rx_msg_id_next     = rx_msg_id_reg;
        rx_type_next       = rx_type_reg;
        rx_length_next     = rx_length_reg;
        has_result         = 1'b0;
        new_result         = '{is_verdict: 1'b0, payload_byte: 8'd0, status: ST_OK,
                               msg_type: 8'd0, payload_len: 8'd0};

        if (accept)
        begin
            if (end_of_packet)
            begin
                has_result             = 1'b1;
                new_result.is_verdict  = 1'b1;
                new_result.status      = verdict;
                new_result.msg_type    = rx_type_reg;
                new_result.payload_len = rx_length_reg;
                byte_count_next        = '0;
                running_crc_next       = CRC_SEED;
                preamble_seen_next     = 1'b0;
                dest_addr_next         = '0;
                rx_msg_id_next         = '0;
                rx_type_next           = '0;
                rx_length_next         = '0;
            end
            else
            begin
                if (pos < CW'(MAX_PACKET_BYTES + 1))
                    byte_count_next = pos + CW'(1);
                running_crc_next = crc_upd;

                case (pos)
                    CW'(POS_PREAMBLE): preamble_seen_next   = (rx_byte == PREAMBLE_BYTE);
                    CW'(POS_DEST):     dest_addr_next       = rx_byte;
                    CW'(POS_ID_HI):    rx_msg_id_next[15:8] = rx_byte;
                    CW'(POS_ID_LO):    rx_msg_id_next[7:0]  = rx_byte;
                    CW'(POS_TYPE):     rx_type_next         = rx_byte;
                    CW'(POS_LEN):      rx_length_next       = rx_byte;
                    default: ;
                endcase

                if (pos >= CW'(HEADER_BYTES) && pos < CW'(MAX_PACKET_BYTES) &&
                    body_bytes < length_ext)
                begin
                    has_result              = 1'b1;
                    new_result.payload_byte = rx_byte;
                end
            end
        end
    end

    // two-entry output buffer; the skid entry fills only while the head is stalled
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = has_result;
                main_next       = new_result;
            end
        end
        else if (!main_valid_reg)
        begin
            main_valid_next = has_result;
            main_next       = new_result;
        end
        else if (has_result)
        begin
            skid_valid_next = 1'b1;
            skid_next       = new_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            running_crc_reg   <= CRC_SEED;
            preamble_seen_reg <= 1'b0;
            dest_addr_reg     <= '0;
            rx_msg_id_reg     <= '0;
            rx_type_reg       <= '0;
            rx_length_reg     <= '0;
            main_valid_reg    <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            byte_count_reg    <= byte_count_next;
            running_crc_reg   <= running_crc_next;
            preamble_seen_reg <= preamble_seen_next;
            dest_addr_reg     <= dest_addr_next;
            rx_msg_id_reg     <= rx_msg_id_next;
            rx_type_reg       <= rx_type_next;
            rx_length_reg     <= rx_length_next;
            main_valid_reg    <= main_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign result_valid = main_valid_reg;
    assign is_verdict   = main_reg.is_verdict;
    assign payload_byte = main_reg.payload_byte;
    assign status       = main_reg.status;
    assign msg_type     = main_reg.msg_type;
    assign payload_len  = main_reg.payload_len;

    `RRD_ASSERT_IMPLY(a_skid_behind_head, skid_valid_reg, main_valid_reg, "skid entry full while head empty")
    `RRD_ASSERT_NEXT(a_clear_after_verdict, accept && end_of_packet, byte_count_reg == '0 && running_crc_reg == CRC_SEED, "packet state not cleared after verdict")
    `RRD_ASSERT_NEXT(a_count_step, accept && !end_of_packet && byte_count_reg < CW'(MAX_PACKET_BYTES + 1), byte_count_reg == $past(byte_count_reg) + CW'(1), "byte count did not advance")
    `RRD_ASSERT_IMPLY(a_count_bound, 1'b1, byte_count_reg <= CW'(MAX_PACKET_BYTES + 1), "byte count past saturation")

endmodule

`default_nettype wire
